// ===== sv/nnki_pkg.sv =====
`timescale 1ns / 1ps

package nnki_pkg;

  localparam int MAX_NAME_LEN = 16;
  localparam int POS_W        = $clog2(MAX_NAME_LEN + 1);
  localparam int KEY_W        = 13;
  localparam int CNT_W        = 5;

  localparam logic [7:0] CH_LOW_A   = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOW_B   = 8'h62;  // 'b'
  localparam logic [7:0] CH_LOW_C   = 8'h63;
  localparam logic [7:0] CH_LOW_D   = 8'h64;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_LOW_G   = 8'h67;
  localparam logic [7:0] CH_LOW_Z   = 8'h7a;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_SHARP   = 8'h23;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  typedef enum logic [1:0] {
    KIND_SCI   = 2'd0,
    KIND_LATIN = 2'd1,
    KIND_HELM  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } char_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_index;
    logic [1:0]              notation_kind;
    logic                    name_too_long;
  } note_item_t;

  typedef struct packed {
    logic [POS_W-1:0] char_position;
    logic [7:0]       first_char;
    logic [7:0]       second_char;
    logic             dash_dropped;
    logic [7:0]       last_kept_char;
    logic [7:0]       prev_kept_char;
    logic [KEY_W-1:0] letter_sum;
    logic [CNT_W-1:0] comma_count;
    logic [CNT_W-1:0] apostrophe_count;
    logic [1:0]       kept_count;
    logic             overflow_seen;
    logic [7:0]       plain_char;
    logic             plain_seen;
  } name_state_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_SHIFT : c;
  endfunction

  function automatic logic [3:0] semitone_of(input logic [7:0] c);
    unique case (to_lower(c))
      CH_LOW_C: semitone_of = 4'd0;
      CH_LOW_D: semitone_of = 4'd2;
      CH_LOW_E: semitone_of = 4'd4;
      CH_LOW_F: semitone_of = 4'd5;
      CH_LOW_G: semitone_of = 4'd7;
      CH_LOW_A: semitone_of = 4'd9;
      CH_LOW_B: semitone_of = 4'd11;
      default:  semitone_of = 4'd0;
    endcase
  endfunction

  // Syllable sums of (ch - 'a'): do, ut, re, mi, fa, sol, la, si.
  function automatic logic [3:0] syllable_semitone(input logic [KEY_W-1:0] sum);
    unique case (sum)
      KEY_W'(17): syllable_semitone = 4'd0;
      KEY_W'(39): syllable_semitone = 4'd0;
      KEY_W'(21): syllable_semitone = 4'd2;
      KEY_W'(20): syllable_semitone = 4'd4;
      KEY_W'(5):  syllable_semitone = 4'd5;
      KEY_W'(43): syllable_semitone = 4'd7;
      KEY_W'(11): syllable_semitone = 4'd9;
      KEY_W'(26): syllable_semitone = 4'd11;
      default:    syllable_semitone = 4'd0;
    endcase
  endfunction

endpackage

// ===== sv/nnki_core.sv =====
`timescale 1ns / 1ps

module nnki_core (
  input  nnki_pkg::name_state_t state,
  input  nnki_pkg::char_item_t  item,
  output nnki_pkg::name_state_t state_next,
  output nnki_pkg::note_item_t  result
);

  localparam int KW = nnki_pkg::KEY_W;

  nnki_pkg::name_state_t upd;
  logic [7:0]            c;
  logic [7:0]            lc;
  logic [7:0]            sc;
  logic [7:0]            lk;
  logic [7:0]            pk;
  logic [7:0]            octch;
  logic [7:0]            letter;
  logic [KW-1:0]         sum;
  logic signed [KW-1:0]  oct;
  logic signed [KW-1:0]  oct12;
  logic signed [KW-1:0]  acc;
  logic [3:0]            semi;
  logic                  popped;
  nnki_pkg::kind_t       kind;

  // Running per-name state, including the current character.
  always_comb begin
    c   = item.char_code;
    lc  = nnki_pkg::to_lower(c);
    upd = state;
    if (state.char_position == '0) begin
      upd.first_char = c;
    end
    if (state.char_position == nnki_pkg::POS_W'(1)) begin
      upd.second_char = c;
    end
    if (lc == nnki_pkg::CH_DASH && !state.dash_dropped) begin
      upd.dash_dropped = 1'b1;
    end else begin
      upd.letter_sum     = state.letter_sum + {5'd0, lc} - {5'd0, nnki_pkg::CH_LOW_A};
      upd.prev_kept_char = state.last_kept_char;
      upd.last_kept_char = lc;
      if (state.kept_count < 2'd2) begin
        upd.kept_count = state.kept_count + 2'd1;
      end
    end
    if (c == nnki_pkg::CH_COMMA && state.comma_count != '1) begin
      upd.comma_count = state.comma_count + nnki_pkg::CNT_W'(1);
    end
    if (c == nnki_pkg::CH_APOS && state.apostrophe_count != '1) begin
      upd.apostrophe_count = state.apostrophe_count + nnki_pkg::CNT_W'(1);
    end
    if (state.char_position < nnki_pkg::POS_W'(nnki_pkg::MAX_NAME_LEN)) begin
      upd.char_position = state.char_position + nnki_pkg::POS_W'(1);
    end else begin
      upd.overflow_seen = 1'b1;
    end
  end

  // Clear after the last character; track the first non-apostrophe otherwise.
  always_comb begin
    state_next = upd;
    if (item.is_final) begin
      state_next = '0;
    end else if (!state.plain_seen && c != nnki_pkg::CH_APOS) begin
      state_next.plain_char = c;
      state_next.plain_seen = 1'b1;
    end
  end

  always_comb begin
    sc = upd.second_char;
    if (state.char_position == '0) begin
      kind = nnki_pkg::KIND_HELM;
    end else if ((sc >= nnki_pkg::CH_LOW_A && sc <= nnki_pkg::CH_LOW_Z) ||
                 (sc >= nnki_pkg::CH_UP_A && sc <= nnki_pkg::CH_UP_Z)) begin
      kind = nnki_pkg::KIND_LATIN;
    end else if (sc >= nnki_pkg::CH_ZERO && sc <= nnki_pkg::CH_NINE) begin
      kind = nnki_pkg::KIND_SCI;
    end else begin
      kind = nnki_pkg::KIND_HELM;
    end
  end

  always_comb begin
    lk     = upd.last_kept_char;
    pk     = upd.prev_kept_char;
    sum    = upd.letter_sum;
    octch  = '0;
    letter = '0;
    popped = 1'b0;
    acc    = '0;
    oct    = '0;
    semi   = '0;
    case (kind)
      nnki_pkg::KIND_SCI: begin
        oct = $signed({5'd0, sc}) - $signed({5'd0, nnki_pkg::CH_ONE});
        if (lc == nnki_pkg::CH_SHARP) begin
          acc = KW'(1);
        end else if (lc == nnki_pkg::CH_LOW_B) begin
          acc = -KW'(1);
        end
        semi = nnki_pkg::semitone_of(upd.first_char);
      end
      nnki_pkg::KIND_LATIN: begin
        // Remove a trailing accidental, then the octave digit, from the sum.
        if (upd.kept_count != 2'd0 &&
            (lk == nnki_pkg::CH_SHARP || lk == nnki_pkg::CH_LOW_B)) begin
          acc = (lk == nnki_pkg::CH_SHARP) ? KW'(1) : -KW'(1);
          sum = sum - {5'd0, lk} + {5'd0, nnki_pkg::CH_LOW_A};
          if (upd.kept_count == 2'd2) begin
            octch = pk;
            sum   = sum - {5'd0, pk} + {5'd0, nnki_pkg::CH_LOW_A};
          end
        end else if (upd.kept_count != 2'd0) begin
          octch = lk;
          sum   = sum - {5'd0, lk} + {5'd0, nnki_pkg::CH_LOW_A};
        end
        oct  = $signed({5'd0, octch}) - $signed({5'd0, nnki_pkg::CH_ZERO});
        semi = nnki_pkg::syllable_semitone(sum);
      end
      default: begin
        popped = state.char_position != '0 &&
                 (c == nnki_pkg::CH_SHARP || c == nnki_pkg::CH_LOW_B);
        if (popped) begin
          acc = (c == nnki_pkg::CH_LOW_B) ? -KW'(1) : KW'(1);
        end
        if (upd.first_char >= nnki_pkg::CH_UP_A && upd.first_char <= nnki_pkg::CH_UP_Z) begin
          oct    = KW'(1) - $signed({{(KW-nnki_pkg::CNT_W){1'b0}}, upd.comma_count});
          letter = upd.first_char;
        end else begin
          oct = KW'(2) + $signed({{(KW-nnki_pkg::CNT_W){1'b0}}, upd.apostrophe_count});
          if (state.plain_seen) begin
            letter = state.plain_char;
          end else if (!popped && c != nnki_pkg::CH_APOS) begin
            letter = c;
          end
        end
        semi = nnki_pkg::semitone_of(letter);
      end
    endcase
    oct12 = (oct <<< 3) + (oct <<< 2);
    result.key_index     = $signed({{(KW-4){1'b0}}, semi}) + KW'(4) + oct12 + acc;
    result.notation_kind = kind;
    result.name_too_long = upd.overflow_seen;
  end

endmodule

// ===== sv/note_name_to_key_index_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload       Handshake
// char     in         char_item_t   char_valid / char_stall
// note     out        note_item_t   note_valid / note_stall
//
// One character is taken per cycle while char_stall is low; the result is
// registered when the character marked final is taken.
// The per-name state and the result are computed in one pass between the
// name state registers and the output register.
// A stalled result holds in the output register; one more result fits in a
// skid register, and char_stall rises only while that skid register is full.
// rst clears the name state and both result valid flags.

module note_name_to_key_index_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  nnki_pkg::char_item_t char_item,
  output logic                 note_valid,
  input  logic                 note_stall,
  output nnki_pkg::note_item_t note_item
);

  nnki_pkg::name_state_t name_state;
  nnki_pkg::name_state_t name_state_next;
  nnki_pkg::note_item_t  result;
  nnki_pkg::note_item_t  skid_item;
  nnki_pkg::note_item_t  note_item_next;
  logic                  skid_valid;
  logic                  skid_valid_next;
  logic                  note_valid_next;
  logic                  accept;
  logic                  res_valid;
  logic                  load_out;
  logic                  load_skid;

  nnki_core u_core (
    .state      (name_state),
    .item       (char_item),
    .state_next (name_state_next),
    .result     (result)
  );

  assign char_stall = skid_valid;
  assign accept     = char_valid && !skid_valid;
  assign res_valid  = accept && char_item.is_final;

  always_comb begin
    note_valid_next = note_valid;
    skid_valid_next = skid_valid;
    note_item_next  = result;
    load_out        = 1'b0;
    load_skid       = 1'b0;
    if (note_valid && !note_stall) begin
      if (skid_valid) begin
        note_item_next  = skid_item;
        load_out        = 1'b1;
        skid_valid_next = 1'b0;
      end else if (res_valid) begin
        load_out = 1'b1;
      end else begin
        note_valid_next = 1'b0;
      end
    end else if (!note_valid) begin
      if (res_valid) begin
        load_out        = 1'b1;
        note_valid_next = 1'b1;
      end
    end else if (res_valid) begin
      // Output held: park the new result.
      load_skid       = 1'b1;
      skid_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_state <= '0;
      note_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        name_state <= name_state_next;
      end
      note_valid <= note_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      note_item <= note_item_next;
    end
    if (load_skid) begin
      skid_item <= result;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> note_valid)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(note_valid && note_stall && res_valid))
    else $error("skid filled without a stalled output and a new result");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> name_state.char_position == '0 && !name_state.plain_seen)
    else $error("name state not cleared after the last character");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (!note_valid && !res_valid) |=> !note_valid)
    else $error("result appeared without a final character");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    name_state.char_position <= nnki_pkg::POS_W'(nnki_pkg::MAX_NAME_LEN))
    else $error("character position beyond the length bound");

endmodule
